// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the heap queue RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/qmhq_pkg.sv =====
// Package for the quaternary min-heap queue: word types, codes, compare.
// Depends on nothing.
`timescale 1ns / 1ps
package qmhq_pkg;
    localparam int DEFAULT_DEPTH = 1024;
    localparam int DEFAULT_ARITY = 4;
    localparam int CNT_W = 11;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [63:0] vruntime;
        logic [15:0] weight;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic        req_type;
        logic [63:0] key_vruntime;
        logic [15:0] key_weight;
        logic [15:0] key_tag;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [63:0]      out_vruntime;
        logic [15:0]      out_weight;
        logic [15:0]      out_tag;
        logic             min_valid;
        logic [63:0]      min_vruntime;
        logic [15:0]      min_weight;
        logic [15:0]      min_tag;
        logic [CNT_W-1:0] entry_count;
    } out_word_t;

    // True when a ranks strictly before b.
    function automatic logic ranks_before(entry_t a, entry_t b);
        if (a.vruntime != b.vruntime)
            return a.vruntime < b.vruntime;
        return a.weight > b.weight;
    endfunction
endpackage

// ===== hdl/qmhq_mem.sv =====
// Heap entry memory: one write port, one read port, registered read data.
// Depends on qmhq_pkg.
`timescale 1ns / 1ps
module qmhq_mem #(
    parameter int DEPTH = qmhq_pkg::DEFAULT_DEPTH,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  qmhq_pkg::entry_t     wdata,
    input  logic [AW-1:0]        raddr,
    output qmhq_pkg::entry_t     rdata
);
    qmhq_pkg::entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read port, read data registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/quaternary_min_heap_queue_unit.sv =====
// Top level of the quaternary min-heap queue: sequencer and output register.
// Depends on qmhq_pkg, qmhq_mem and assert_macros.svh.
`timescale 1ns / 1ps
// One request at a time. A push writes the new entry at the end, then walks
// up: each level reads the parent and swaps if the new entry ranks
// first, one write per cycle. A pop reads root and last entry, writes the
// last at the root, then walks down: each level reads up to ARITY children
// one per cycle and swaps in 2 writes, over log_ARITY(depth) levels. The
// entry memory has one read and one write per cycle with registered read
// data. A refused request finishes from idle. The result sits in an output
// register; the next request is taken once the output is free.
module quaternary_min_heap_queue_unit #(
    parameter int HEAP_DEPTH = qmhq_pkg::DEFAULT_DEPTH,
    parameter int ARITY = qmhq_pkg::DEFAULT_ARITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qmhq_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output qmhq_pkg::out_word_t out_data
);
    `include "assert_macros.svh"

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = qmhq_pkg::CNT_W;
    localparam int KW = $clog2(ARITY + 1);
    localparam int PW = AW + 4;
    // Reciprocal of ARITY for the parent index
    localparam int RS = AW + 3;
    localparam int RW = AW + RS + 2;
    localparam logic [RW-1:0] RECIP = RW'((2 ** RS + ARITY - 1) / ARITY);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPRD   = 4'd1;
    localparam logic [3:0] S_UPCMP  = 4'd2;
    localparam logic [3:0] S_UPWR   = 4'd3;
    localparam logic [3:0] S_POPLST = 4'd4;
    localparam logic [3:0] S_POPWR  = 4'd5;
    localparam logic [3:0] S_DNRD   = 4'd6;
    localparam logic [3:0] S_DNWR   = 4'd7;
    localparam logic [3:0] S_ROOT   = 4'd8;
    localparam logic [3:0] S_ROOTW  = 4'd9;
    localparam logic [3:0] S_POPRT  = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     best_reg, best_next;
    logic [KW-1:0]     k_reg, k_next;
    qmhq_pkg::entry_t  cur_reg, cur_next;
    qmhq_pkg::entry_t  bestv_reg, bestv_next;
    qmhq_pkg::entry_t  pop_reg, pop_next;
    logic              is_pop_reg, is_pop_next;
    logic              out_valid_reg;
    qmhq_pkg::out_word_t out_reg;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    qmhq_pkg::entry_t  wdata, rdata;
    logic              finish;
    logic [1:0]        fin_status;
    logic [PW-1:0]     child_w;
    logic [PW-1:0]     parent_w;
    logic [RW-1:0]     parent_prod;

    qmhq_mem #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // Index arithmetic for the walk
    assign parent_prod = RW'(pos_reg - AW'(1)) * RECIP;
    assign parent_w = PW'(parent_prod >> RS);
    assign child_w = PW'(pos_reg) * PW'(ARITY) + PW'(1) + PW'(k_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        pos_next = pos_reg;
        best_next = best_reg;
        k_next = k_reg;
        cur_next = cur_reg;
        bestv_next = bestv_reg;
        pop_next = pop_reg;
        is_pop_next = is_pop_reg;
        we = 1'b0;
        waddr = pos_reg;
        wdata = cur_reg;
        raddr = '0;
        finish = 1'b0;
        fin_status = qmhq_pkg::ST_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    is_pop_next = in_data.req_type;
                    if (in_data.req_type == qmhq_pkg::REQ_PUSH)
                    begin
                        if (fill_reg >= CW'(HEAP_DEPTH))
                        begin
                            finish = 1'b1;
                            fin_status = qmhq_pkg::ST_FULL;
                            state_next = S_ROOT;
                        end
                        else
                        begin
                            cur_next = '{in_data.key_vruntime, in_data.key_weight,
                                         in_data.key_tag};
                            we = 1'b1;
                            waddr = fill_reg[AW-1:0];
                            wdata = cur_next;
                            pos_next = fill_reg[AW-1:0];
                            fill_next = fill_reg + CW'(1);
                            state_next = (fill_reg == '0) ? S_ROOT : S_UPRD;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        finish = 1'b1;
                        fin_status = qmhq_pkg::ST_EMPTY;
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        raddr = '0;
                        fill_next = fill_reg - CW'(1);
                        state_next = S_POPRT;
                    end
                end
            end
            S_POPRT:
            begin
                pop_next = rdata;
                raddr = fill_reg[AW-1:0];
                state_next = (fill_reg == '0) ? S_ROOT : S_POPLST;
            end
            S_POPLST:
            begin
                cur_next = rdata;
                pos_next = '0;
                state_next = S_POPWR;
            end
            S_POPWR:
            begin
                we = 1'b1;
                waddr = '0;
                wdata = cur_reg;
                best_next = pos_reg;
                bestv_next = cur_reg;
                k_next = '0;
                state_next = S_DNRD;
            end
            // Issue one child read per cycle, compare the previous read
            S_DNRD:
            begin
                if (k_reg != '0 && qmhq_pkg::ranks_before(rdata, bestv_reg))
                begin
                    bestv_next = rdata;
                    best_next = AW'(child_w - PW'(1));
                end
                if (k_reg == KW'(ARITY) || child_w >= PW'(fill_reg))
                begin
                    if (best_next == pos_reg)
                        state_next = S_ROOT;
                    else
                        state_next = S_DNWR;
                end
                else
                begin
                    raddr = AW'(child_w);
                    k_next = k_reg + KW'(1);
                end
            end
            S_DNWR:
            begin
                // Two writes: child value to parent, then cur to child
                we = 1'b1;
                if (k_reg != '0)
                begin
                    waddr = pos_reg;
                    wdata = bestv_reg;
                    k_next = '0;
                end
                else
                begin
                    waddr = best_reg;
                    wdata = cur_reg;
                    pos_next = best_reg;
                    bestv_next = cur_reg;
                    state_next = S_DNRD;
                end
            end
            S_UPRD:
            begin
                if (pos_reg == '0)
                    state_next = S_ROOT;
                else
                begin
                    raddr = AW'(parent_w);
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                bestv_next = rdata;
                best_next = AW'(parent_w);
                k_next = '0;
                state_next = qmhq_pkg::ranks_before(cur_reg, rdata) ? S_UPWR : S_ROOT;
            end
            S_UPWR:
            begin
                we = 1'b1;
                if (k_reg == '0)
                begin
                    waddr = pos_reg;
                    wdata = bestv_reg;
                    k_next = KW'(1);
                end
                else
                begin
                    waddr = best_reg;
                    wdata = cur_reg;
                    pos_next = best_reg;
                    state_next = S_UPRD;
                end
            end
            S_ROOT:
            begin
                raddr = '0;
                state_next = S_ROOTW;
            end
            S_ROOTW:
            begin
                finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            k_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= (finish && state_reg == S_IDLE) ? S_IDLE : state_next;
            fill_reg <= fill_next;
            k_reg <= k_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        best_reg <= best_next;
        cur_reg <= cur_next;
        bestv_reg <= bestv_next;
        pop_reg <= pop_next;
        is_pop_reg <= is_pop_next;
        if (finish)
        begin
            out_reg.status <= fin_status;
            out_reg.entry_count <= fill_reg;
            out_reg.min_valid <= (fill_reg != '0);
            if (state_reg == S_IDLE)
            begin
                // Refused request: heap unchanged, root taken from last result
                out_reg.out_vruntime <= '0;
                out_reg.out_weight <= '0;
                out_reg.out_tag <= '0;
                if (fill_reg == '0)
                begin
                    out_reg.min_vruntime <= '0;
                    out_reg.min_weight <= '0;
                    out_reg.min_tag <= '0;
                end
            end
            else
            begin
                if (is_pop_reg)
                begin
                    out_reg.out_vruntime <= pop_reg.vruntime;
                    out_reg.out_weight <= pop_reg.weight;
                    out_reg.out_tag <= pop_reg.tag;
                end
                else
                begin
                    out_reg.out_vruntime <= '0;
                    out_reg.out_weight <= '0;
                    out_reg.out_tag <= '0;
                end
                if (fill_reg != '0)
                begin
                    out_reg.min_vruntime <= rdata.vruntime;
                    out_reg.min_weight <= rdata.weight;
                    out_reg.min_tag <= rdata.tag;
                end
                else
                begin
                    out_reg.min_vruntime <= '0;
                    out_reg.min_weight <= '0;
                    out_reg.min_tag <= '0;
                end
            end
        end
    end

    // Checks
    `ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_reg <= CW'(HEAP_DEPTH))
    `ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready && !finish,
                 state_reg != S_IDLE)
endmodule
